/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the core RTL. Both expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(label, ante, cons)
`define ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/core/lbbs_pkg.sv */
// ----------------------------------------------------------------------------
// lbbs_pkg
// Shared types and constants of the LED / buzzer blink sequencer.
// ----------------------------------------------------------------------------
package lbbs_pkg;

  localparam int COUNT_WIDTH_DEF = 8;

  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 8;

  // command codes
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_START   = 2'd1;
  localparam logic [1:0] CMD_SET_ON  = 2'd2;
  localparam logic [1:0] CMD_SET_OFF = 2'd3;

  // per-channel request for one item
  typedef struct packed {
    logic tick;
    logic start;
  } lbbs_req_t;

  // pin drive event raised by a phase change
  typedef struct packed {
    logic drive;
    logic on;
  } lbbs_drv_t;

endpackage

/* rtl/core/lbbs_chan.sv */
// ----------------------------------------------------------------------------
// lbbs_chan
// One blink channel: phase, tick counter, cycle counter and latched lengths.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lbbs_chan #(
  parameter int COUNT_WIDTH = lbbs_pkg::COUNT_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lbbs_pkg::lbbs_req_t    req,
  input  logic [COUNT_WIDTH-1:0] delay_len,
  input  logic [COUNT_WIDTH-1:0] count_len,
  input  logic [COUNT_WIDTH-1:0] on_len,
  input  logic [COUNT_WIDTH-1:0] off_len,
  output lbbs_pkg::lbbs_drv_t    drv,
  output logic                   busy_nxt
);
  import lbbs_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_DELAY = 2'd1;
  localparam logic [1:0] PH_ON    = 2'd2;
  localparam logic [1:0] PH_OFF   = 2'd3;

  localparam logic [COUNT_WIDTH-1:0] ONE  = COUNT_WIDTH'(1);
  localparam logic [COUNT_WIDTH-1:0] ZERO = '0;

  logic [1:0]             phase_r,  phase_nxt;
  logic [COUNT_WIDTH-1:0] ticks_r,  ticks_nxt;
  logic [COUNT_WIDTH-1:0] cycles_r, cycles_nxt;
  logic [COUNT_WIDTH-1:0] on_r,     on_nxt;
  logic [COUNT_WIDTH-1:0] off_r,    off_nxt;
  logic [COUNT_WIDTH-1:0] cyc_dec;

  always_comb begin
    phase_nxt  = phase_r;
    ticks_nxt  = ticks_r;
    cycles_nxt = cycles_r;
    on_nxt     = on_r;
    off_nxt    = off_r;
    drv        = '0;
    cyc_dec    = (cycles_r != ZERO) ? cycles_r - ONE : ZERO;
    if (req.start) begin
      phase_nxt  = PH_DELAY;
      ticks_nxt  = (delay_len == ZERO) ? ONE : delay_len;
      cycles_nxt = count_len;
      on_nxt     = on_len;
      off_nxt    = off_len;
    end else if (req.tick && phase_r != PH_IDLE) begin
      if (ticks_r > ONE) begin
        ticks_nxt = ticks_r - ONE;
      end else if (phase_r == PH_ON) begin
        drv.drive  = 1'b1;
        drv.on     = 1'b0;
        cycles_nxt = cyc_dec;
        if (cyc_dec == ZERO) begin
          phase_nxt = PH_IDLE;
          ticks_nxt = ZERO;
        end else begin
          phase_nxt = PH_OFF;
          ticks_nxt = (off_r == ZERO) ? ONE : off_r;
        end
      end else begin
        // delay or off phase over: light up
        drv.drive = 1'b1;
        drv.on    = 1'b1;
        phase_nxt = PH_ON;
        ticks_nxt = (on_r == ZERO) ? ONE : on_r;
      end
    end
  end

  assign busy_nxt = (phase_nxt != PH_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      ticks_r  <= '0;
      cycles_r <= '0;
      on_r     <= '0;
      off_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      ticks_r  <= ticks_nxt;
      cycles_r <= cycles_nxt;
      on_r     <= on_nxt;
      off_r    <= off_nxt;
    end
  end

  `ASSERT_IMPL(a_idle_no_ticks, phase_r == PH_IDLE, ticks_r == ZERO)
  `ASSERT_IMPL(a_run_has_ticks, phase_r != PH_IDLE, ticks_r != ZERO && cycles_r != ZERO)
  `ASSERT_NEXT(a_start_delay, req.start, phase_r == PH_DELAY)

endmodule

/* rtl/core/led_buzzer_blink_sequencer_core.sv */
// ----------------------------------------------------------------------------
// led_buzzer_blink_sequencer_core
// Two-channel blink sequencer: active-high LED and active-low buzzer.
// ----------------------------------------------------------------------------
//  channel  dir  ports                               item
//  in       in   in_tvalid/in_tready/in_tdata/in_tuser  one command or tick
//  out      out  out_tvalid/out_tready/out_tdata     pin levels and busy flags
//
//  One item per clock unless output stalls; items pass the input register, then
//  the result register. State for both channels updates in the cycle an item
//  leaves the input register, so the next item sees it at once.
//  Synchronous active-low reset: both channels idle, LED off, buzzer silent.
//  A stalled output holds its item; the input register keeps taking items
//  whenever it is empty or moving on.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module led_buzzer_blink_sequencer_core #(
  parameter int COUNT_WIDTH = lbbs_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [7:0] start_delay, [15:8] repeat_count, [23:16] on_ticks, [31:24] off_ticks
  input  logic [lbbs_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [1:0] cmd, [2] channel
  input  logic [lbbs_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [0] led_pin, [1] buzzer_pin, [2] led_busy, [3] buzzer_busy, [7:4] zero
  output logic [lbbs_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import lbbs_pkg::*;

  // counter loads saturate at the counter maximum when it is under 8 bits
  localparam int LW = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
  localparam logic [LW-1:0] SAT_MAX = LW'((64'd1 << COUNT_WIDTH) - 64'd1);

  function automatic logic [COUNT_WIDTH-1:0] sat_cnt(input logic [7:0] v);
    logic [LW-1:0] x;
    x = LW'(v);
    return COUNT_WIDTH'((x > SAT_MAX) ? SAT_MAX : x);
  endfunction

  // input register
  logic       in_vld_r;
  logic [1:0] cmd_r;
  logic       chan_r;
  logic [7:0] delay_r, count_r, on_r, off_r;

  // result register
  logic                   out_vld_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  // shared pin levels
  logic led_r, led_nxt;
  logic buz_r, buz_nxt;

  logic out_adv, proc;
  logic [COUNT_WIDTH-1:0] delay_s, count_s, on_s, off_s;

  lbbs_req_t req   [2];
  lbbs_drv_t drv   [2];
  logic      busy_n[2];

  assign out_adv   = !out_vld_r || out_tready;
  assign proc      = in_vld_r && out_adv;   // item applied this cycle
  assign in_tready = !in_vld_r || out_adv;

  assign delay_s = sat_cnt(delay_r);
  assign count_s = sat_cnt(count_r);
  assign on_s    = sat_cnt(on_r);
  assign off_s   = sat_cnt(off_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r   <= in_tuser[1:0];
      chan_r  <= in_tuser[2];
      delay_r <= in_tdata[7:0];
      count_r <= in_tdata[15:8];
      on_r    <= in_tdata[23:16];
      off_r   <= in_tdata[31:24];
    end
  end

  // per-channel requests; a zero count start is dropped here
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      req[c].tick  = proc && (cmd_r == CMD_TICK);
      req[c].start = proc && (cmd_r == CMD_START) && (chan_r == 1'(c)) &&
                     (count_s != '0);
    end
  end

  lbbs_chan #(.COUNT_WIDTH(COUNT_WIDTH)) u_led_chan (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req[0]),
    .delay_len (delay_s),
    .count_len (count_s),
    .on_len    (on_s),
    .off_len   (off_s),
    .drv       (drv[0]),
    .busy_nxt  (busy_n[0])
  );

  lbbs_chan #(.COUNT_WIDTH(COUNT_WIDTH)) u_buz_chan (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req[1]),
    .delay_len (delay_s),
    .count_len (count_s),
    .on_len    (on_s),
    .off_len   (off_s),
    .drv       (drv[1]),
    .busy_nxt  (busy_n[1])
  );

  // pin levels: phase changes on ticks, direct set on set commands
  always_comb begin
    led_nxt = led_r;
    buz_nxt = buz_r;
    if (drv[0].drive) begin
      led_nxt = drv[0].on;
    end
    if (drv[1].drive) begin
      buz_nxt = !drv[1].on;   // buzzer is active low
    end
    if (proc && (cmd_r == CMD_SET_ON || cmd_r == CMD_SET_OFF)) begin
      if (!chan_r) begin
        led_nxt = (cmd_r == CMD_SET_ON);
      end else begin
        buz_nxt = (cmd_r != CMD_SET_ON);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_r     <= 1'b0;
      buz_r     <= 1'b1;
      out_vld_r <= 1'b0;
    end else begin
      led_r <= led_nxt;
      buz_r <= buz_nxt;
      if (out_adv) begin
        out_vld_r <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_data_r <= {(OUT_TDATA_W - 4)'(0), busy_n[1], busy_n[0], buz_nxt, led_nxt};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule
